// ===== hw/rtl/fsq_pkg.sv =====
// four-square cipher package: request codes, letter constants and cell helpers
package fsq_pkg;

   // request codes
   localparam logic [2:0] REQ_CLEAR    = 3'd0;
   localparam logic [2:0] REQ_KEY1     = 3'd1;
   localparam logic [2:0] REQ_KEY2     = 3'd2;
   localparam logic [2:0] REQ_FINALIZE = 3'd3;
   localparam logic [2:0] REQ_ENCRYPT  = 3'd4;
   localparam logic [2:0] REQ_DECRYPT  = 3'd5;

   // status codes
   localparam logic STATUS_OK     = 1'b0;
   localparam logic STATUS_REJECT = 1'b1;

   // letters and square geometry
   localparam logic [4:0] LETTER_I = 5'd8;
   localparam logic [4:0] LETTER_J = 5'd9;
   localparam logic [4:0] LETTER_X = 5'd23;
   localparam logic [4:0] LETTER_Z = 5'd25;
   localparam logic [4:0] CELLS    = 5'd25;
   localparam int         LETTERS  = 26;

   typedef logic [4:0] letter_type;
   typedef logic [2:0] row_type;

   // clamp to Z and merge J into I
   function automatic letter_type norm_letter(input letter_type v);
      letter_type l;
      l = (v > LETTER_Z) ? LETTER_Z : v;
      return (l == LETTER_J) ? LETTER_I : l;
   endfunction

   // letter to cell of the plain alphabet square
   function automatic letter_type plain_cell(input letter_type l);
      return (l > LETTER_J) ? l - 5'd1 : l;
   endfunction

   // cell of the plain alphabet square to letter
   function automatic letter_type plain_letter(input letter_type c);
      return (c >= LETTER_J) ? c + 5'd1 : c;
   endfunction

   // row of a cell, by compares
   function automatic row_type cell_row(input letter_type c);
      row_type r;
      if (c >= 5'd20) begin
         r = 3'd4;
      end else if (c >= 5'd15) begin
         r = 3'd3;
      end else if (c >= 5'd10) begin
         r = 3'd2;
      end else if (c >= 5'd5) begin
         r = 3'd1;
      end else begin
         r = 3'd0;
      end
      return r;
   endfunction

   // column of a cell
   function automatic letter_type cell_col(input letter_type c);
      letter_type r;
      r = {2'b00, cell_row(c)};
      return c - ((r << 2) + r);
   endfunction

   // cell at row of one cell and column of another
   function automatic letter_type cross_cell(input letter_type row_src,
                                             input letter_type col_src);
      letter_type r;
      r = {2'b00, cell_row(row_src)};
      return (r << 2) + r + cell_col(col_src);
   endfunction

endpackage

// ===== hw/rtl/four_square_digraph_cipher_top.sv =====
// four-square cipher engine: key square build, finalize fill and pair lookup
// result: clear, key letter, finalize and rejected requests load the output register on accept;
//   encrypt and decrypt pass one memory read register, then the output register
// stalls: clear and rejects keep the block idle; key letter, cipher pairs and finalize stall
//   requests; finalize steps 26 letters, each a square write and a map write on the same port
// reset: synchronous, clears phase, used masks, fill counts and output valid; memories kept
module four_square_digraph_cipher_top (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [2:0]             req_type,
   input  fsq_pkg::letter_type    req_letter_first,
   input  fsq_pkg::letter_type    req_letter_second,
   input  logic                   req_second_present,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output fsq_pkg::letter_type    rsp_out_first,
   output fsq_pkg::letter_type    rsp_out_second,
   output logic                   rsp_status
);
   import fsq_pkg::*;

   // sequencer states
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_PLACE  = 3'd1;
   localparam logic [2:0] ST_FILL0  = 3'd2;
   localparam logic [2:0] ST_FILL1  = 3'd3;
   localparam logic [2:0] ST_LOOKUP = 3'd4;

   // memory halves: square cells below, letter-to-cell map above
   localparam logic SEL_SQUARE = 1'b0;
   localparam logic SEL_MAP    = 1'b1;

   logic [2:0]        state_ff, state_in;
   logic              keys_ready_ff, keys_ready_in;
   logic [LETTERS-1:0] u_used_ff, u_used_in, l_used_ff, l_used_in;
   letter_type        u_cnt_ff, u_cnt_in, l_cnt_ff, l_cnt_in;
   letter_type        letter_ff, letter_in;
   logic              u_sel_ff, u_sel_in, l_sel_ff, l_sel_in;
   logic              dec_ff, dec_in;
   logic              rsp_valid_ff, rsp_valid_in;
   letter_type        rsp_first_ff, rsp_first_in, rsp_second_ff, rsp_second_in;
   logic              rsp_status_ff, rsp_status_in;
   logic              rsp_load;

   // key memories, one per square
   logic [4:0]        u_mem [0:63];
   logic [4:0]        l_mem [0:63];
   logic [5:0]        u_waddr, l_waddr, u_raddr, l_raddr;
   letter_type        u_wdata, l_wdata;
   logic              u_we, l_we;
   letter_type        u_rd_ff, l_rd_ff;

   logic              req_fire;
   letter_type        key_letter, pair_a, pair_b;
   letter_type        pl;
   logic              phase_map;
   logic              u_sel, l_sel, u_go, l_go;
   logic              key_ok;

   assign req_stall      = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign req_fire       = req_valid && !req_stall;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_first  = rsp_first_ff;
   assign rsp_out_second = rsp_second_ff;
   assign rsp_status     = rsp_status_ff;

   // normalized letters of the request
   assign key_letter = norm_letter(req_letter_first);
   assign pair_a     = norm_letter(req_letter_first);
   assign pair_b     = req_second_present ? norm_letter(req_letter_second) : LETTER_X;
   assign key_ok     = req_fire && !keys_ready_ff && (req_letter_first <= LETTER_Z);

   // letter being placed and which squares take it
   always_comb begin
      pl        = letter_ff;
      phase_map = (state_ff == ST_PLACE) || (state_ff == ST_FILL1);
      u_sel     = 1'b0;
      l_sel     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            pl    = key_letter;
            u_sel = key_ok && (req_type == REQ_KEY1);
            l_sel = key_ok && (req_type == REQ_KEY2);
         end
         ST_PLACE, ST_FILL0, ST_FILL1: begin
            u_sel = u_sel_ff;
            l_sel = l_sel_ff;
         end
         default: begin
            u_sel = 1'b0;
            l_sel = 1'b0;
         end
      endcase
      u_go = u_sel && (pl != LETTER_J) && !u_used_ff[pl] && (u_cnt_ff < CELLS);
      l_go = l_sel && (pl != LETTER_J) && !l_used_ff[pl] && (l_cnt_ff < CELLS);
   end

   // write port: square cell first, then the map entry
   always_comb begin
      u_we    = u_go;
      l_we    = l_go;
      u_waddr = phase_map ? {SEL_MAP, pl} : {SEL_SQUARE, u_cnt_ff};
      l_waddr = phase_map ? {SEL_MAP, pl} : {SEL_SQUARE, l_cnt_ff};
      u_wdata = phase_map ? u_cnt_ff : pl;
      l_wdata = phase_map ? l_cnt_ff : pl;
   end

   // read port: square cell for encrypt, map entry for decrypt
   always_comb begin
      if (req_type == REQ_DECRYPT) begin
         u_raddr = {SEL_MAP, pair_a};
         l_raddr = {SEL_MAP, pair_b};
      end else begin
         u_raddr = {SEL_SQUARE, cross_cell(plain_cell(pair_a), plain_cell(pair_b))};
         l_raddr = {SEL_SQUARE, cross_cell(plain_cell(pair_b), plain_cell(pair_a))};
      end
   end

   // key memories
   always_ff @(posedge clock) begin
      if (u_we) begin
         u_mem[u_waddr] <= u_wdata;
      end
      if (l_we) begin
         l_mem[l_waddr] <= l_wdata;
      end
      u_rd_ff <= u_mem[u_raddr];
      l_rd_ff <= l_mem[l_raddr];
   end

   // sequencer and result selection
   always_comb begin
      state_in      = state_ff;
      keys_ready_in = keys_ready_ff;
      u_used_in     = u_used_ff;
      l_used_in     = l_used_ff;
      u_cnt_in      = u_cnt_ff;
      l_cnt_in      = l_cnt_ff;
      letter_in     = letter_ff;
      u_sel_in      = u_sel_ff;
      l_sel_in      = l_sel_ff;
      dec_in        = dec_ff;
      rsp_load      = 1'b0;
      rsp_first_in  = 5'd0;
      rsp_second_in = 5'd0;
      rsp_status_in = STATUS_OK;

      // map write cycle commits the placement
      if (phase_map && u_go) begin
         u_used_in[pl] = 1'b1;
         if (pl == LETTER_I) begin
            u_used_in[LETTER_J] = 1'b1;
         end
         u_cnt_in = u_cnt_ff + 5'd1;
      end
      if (phase_map && l_go) begin
         l_used_in[pl] = 1'b1;
         if (pl == LETTER_I) begin
            l_used_in[LETTER_J] = 1'b1;
         end
         l_cnt_in = l_cnt_ff + 5'd1;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               rsp_load = 1'b1;
               case (req_type)
                  REQ_CLEAR: begin
                     u_used_in     = '0;
                     l_used_in     = '0;
                     u_cnt_in      = 5'd0;
                     l_cnt_in      = 5'd0;
                     keys_ready_in = 1'b0;
                  end
                  REQ_KEY1, REQ_KEY2: begin
                     if (keys_ready_ff) begin
                        rsp_status_in = STATUS_REJECT;
                     end else begin
                        letter_in = key_letter;
                        u_sel_in  = u_sel;
                        l_sel_in  = l_sel;
                        state_in  = ST_PLACE;
                     end
                  end
                  REQ_FINALIZE: begin
                     if (keys_ready_ff) begin
                        rsp_status_in = STATUS_REJECT;
                     end else begin
                        keys_ready_in = 1'b1;
                        letter_in     = 5'd0;
                        u_sel_in      = 1'b1;
                        l_sel_in      = 1'b1;
                        state_in      = ST_FILL0;
                     end
                  end
                  REQ_ENCRYPT, REQ_DECRYPT: begin
                     if (!keys_ready_ff) begin
                        rsp_status_in = STATUS_REJECT;
                     end else begin
                        rsp_load = 1'b0;
                        dec_in   = (req_type == REQ_DECRYPT);
                        state_in = ST_LOOKUP;
                     end
                  end
                  default: begin
                     rsp_status_in = STATUS_REJECT;
                  end
               endcase
            end
         end
         ST_PLACE: begin
            state_in = ST_IDLE;
         end
         ST_FILL0: begin
            state_in = ST_FILL1;
         end
         ST_FILL1: begin
            if (letter_ff == LETTER_Z) begin
               state_in = ST_IDLE;
            end else begin
               letter_in = letter_ff + 5'd1;
               state_in  = ST_FILL0;
            end
         end
         ST_LOOKUP: begin
            rsp_load = 1'b1;
            if (dec_ff) begin
               rsp_first_in  = plain_letter(cross_cell(u_rd_ff, l_rd_ff));
               rsp_second_in = plain_letter(cross_cell(l_rd_ff, u_rd_ff));
            end else begin
               rsp_first_in  = u_rd_ff;
               rsp_second_in = l_rd_ff;
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // output register
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         keys_ready_ff <= 1'b0;
         u_used_ff     <= '0;
         l_used_ff     <= '0;
         u_cnt_ff      <= 5'd0;
         l_cnt_ff      <= 5'd0;
         u_sel_ff      <= 1'b0;
         l_sel_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         keys_ready_ff <= keys_ready_in;
         u_used_ff     <= u_used_in;
         l_used_ff     <= l_used_in;
         u_cnt_ff      <= u_cnt_in;
         l_cnt_ff      <= l_cnt_in;
         u_sel_ff      <= u_sel_in;
         l_sel_ff      <= l_sel_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      letter_ff <= letter_in;
      dec_ff    <= dec_in;
      if (rsp_load) begin
         rsp_first_ff  <= rsp_first_in;
         rsp_second_ff <= rsp_second_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   // a lookup always ends in a presented result
   a_lookup_result: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LOOKUP |=> rsp_valid_ff)
      else $error("lookup did not present a result");

   // fill counts stay within the square
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      u_cnt_ff <= CELLS && l_cnt_ff <= CELLS)
      else $error("fill count beyond square size");

   // once finalize is done both squares are full
   a_squares_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && keys_ready_ff) |-> (u_cnt_ff == CELLS && l_cnt_ff == CELLS))
      else $error("cipher phase with a partly filled square");

   // an accepted pair in the cipher phase goes to lookup
   a_pair_lookup: assert property (@(posedge clock) disable iff (reset)
      (req_fire && keys_ready_ff && (req_type == REQ_ENCRYPT || req_type == REQ_DECRYPT))
      |=> state_ff == ST_LOOKUP)
      else $error("accepted pair did not start a lookup");

endmodule

// ===== dv/four_square_digraph_cipher_checker.sv =====
// checker for the four-square cipher engine: predicts each request's result and compares
module four_square_digraph_cipher_checker (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_stall,
   input  logic [2:0]          req_type,
   input  fsq_pkg::letter_type req_letter_first,
   input  fsq_pkg::letter_type req_letter_second,
   input  logic                req_second_present,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  fsq_pkg::letter_type rsp_out_first,
   input  fsq_pkg::letter_type rsp_out_second,
   input  logic                rsp_status,
   output int                  error_count,
   output int                  pending_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import fsq_pkg::*;

   localparam int SQUARE_SIDE  = 5;
   localparam int SQUARE_CELLS = 25;

   typedef struct packed {
      letter_type first;
      letter_type second;
      logic       status;
   } cipher_result_type;

   // shadow copy of both key squares, index 0 is key square 1, index 1 is key square 2
   letter_type         key_square [2][SQUARE_CELLS];
   letter_type         cell_of_letter [2][LETTERS];
   logic [LETTERS-1:0] letters_used [2];
   int                 fill_count [2];
   logic               keys_ready;

   cipher_result_type expected_results [$];
   int                mismatches;

   // clamp above Z, then fold J onto I
   function automatic letter_type fold_letter(input letter_type v);
      letter_type l;
      l = v;
      if (l > LETTER_Z) begin
         l = LETTER_Z;
      end
      if (l == LETTER_J) begin
         l = LETTER_I;
      end
      return l;
   endfunction

   // position of a letter in the 25-letter alphabet square
   function automatic int alphabet_cell(input letter_type l);
      return (l > LETTER_J) ? int'(l) - 1 : int'(l);
   endfunction

   // letter at a position of the 25-letter alphabet square
   function automatic letter_type alphabet_letter(input int c);
      return (c >= int'(LETTER_J)) ? letter_type'(c + 1) : letter_type'(c);
   endfunction

   // append a letter to a key square unless already there or the square is full
   function void place_letter(input int sq, input letter_type l);
      if (letters_used[sq][l] || fill_count[sq] >= SQUARE_CELLS) begin
         return;
      end
      key_square[sq][fill_count[sq]] = l;
      cell_of_letter[sq][l] = letter_type'(fill_count[sq]);
      letters_used[sq][l] = 1'b1;
      if (l == LETTER_I) begin
         letters_used[sq][LETTER_J] = 1'b1;
      end
      fill_count[sq]++;
   endfunction

   // apply one request to the shadow state and return the result it must produce
   function cipher_result_type predict_cipher_result(input logic [2:0]  kind,
                                                     input letter_type first_letter,
                                                     input letter_type second_letter,
                                                     input logic       second_valid);
      cipher_result_type r;
      letter_type        a;
      letter_type        b;
      int                ca;
      int                cb;
      r = '0;
      r.status = STATUS_OK;
      case (kind)
         REQ_CLEAR: begin
            for (int sq = 0; sq < 2; sq++) begin
               letters_used[sq] = '0;
               fill_count[sq] = 0;
            end
            keys_ready = 1'b0;
         end
         REQ_KEY1, REQ_KEY2: begin
            if (keys_ready) begin
               r.status = STATUS_REJECT;
            end else if (first_letter <= LETTER_Z) begin
               place_letter((kind == REQ_KEY1) ? 0 : 1, fold_letter(first_letter));
            end
         end
         REQ_FINALIZE: begin
            if (keys_ready) begin
               r.status = STATUS_REJECT;
            end else begin
               // fill the rest of each square in alphabet order, J left out
               for (int sq = 0; sq < 2; sq++) begin
                  for (int l = 0; l < LETTERS; l++) begin
                     if (letter_type'(l) != LETTER_J) begin
                        place_letter(sq, letter_type'(l));
                     end
                  end
               end
               keys_ready = 1'b1;
            end
         end
         REQ_ENCRYPT, REQ_DECRYPT: begin
            if (!keys_ready) begin
               r.status = STATUS_REJECT;
            end else begin
               a = fold_letter(first_letter);
               b = second_valid ? fold_letter(second_letter) : LETTER_X;
               if (kind == REQ_ENCRYPT) begin
                  // plain pair positions, then swap columns across the key squares
                  ca = alphabet_cell(a);
                  cb = alphabet_cell(b);
                  r.first  = key_square[0][(ca / SQUARE_SIDE) * SQUARE_SIDE + cb % SQUARE_SIDE];
                  r.second = key_square[1][(cb / SQUARE_SIDE) * SQUARE_SIDE + ca % SQUARE_SIDE];
               end else begin
                  // key square positions, then back through the plain alphabet
                  ca = int'(cell_of_letter[0][a]) % SQUARE_CELLS;
                  cb = int'(cell_of_letter[1][b]) % SQUARE_CELLS;
                  r.first  = alphabet_letter((ca / SQUARE_SIDE) * SQUARE_SIDE + cb % SQUARE_SIDE);
                  r.second = alphabet_letter((cb / SQUARE_SIDE) * SQUARE_SIDE + ca % SQUARE_SIDE);
               end
            end
         end
         default: begin
            r.status = STATUS_REJECT;
         end
      endcase
      return r;
   endfunction

   // result side first, since a result always belongs to an older request
   always @(posedge clock) begin
      cipher_result_type want;
      if (reset) begin
         for (int sq = 0; sq < 2; sq++) begin
            letters_used[sq] = '0;
            fill_count[sq] = 0;
            for (int c = 0; c < SQUARE_CELLS; c++) begin
               key_square[sq][c] = '0;
            end
            for (int l = 0; l < LETTERS; l++) begin
               cell_of_letter[sq][l] = '0;
            end
         end
         keys_ready = 1'b0;
         expected_results.delete();
         mismatches = 0;
         error_count <= 0;
         pending_count <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $error("result with no request waiting: out_first %0d out_second %0d status %0d",
                      rsp_out_first, rsp_out_second, rsp_status);
               mismatches++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_out_first !== want.first) begin
                  $error("out_first mismatch: expected %0d, actual %0d", want.first, rsp_out_first);
                  mismatches++;
               end
               if (rsp_out_second !== want.second) begin
                  $error("out_second mismatch: expected %0d, actual %0d",
                         want.second, rsp_out_second);
                  mismatches++;
               end
               if (rsp_status !== want.status) begin
                  $error("status mismatch: expected %0d, actual %0d", want.status, rsp_status);
                  mismatches++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            expected_results.push_back(predict_cipher_result(req_type, req_letter_first,
                                                             req_letter_second,
                                                             req_second_present));
         end
         error_count <= mismatches;
         pending_count <= expected_results.size();
      end
   end

endmodule

// ===== dv/four_square_digraph_cipher_top_tb.sv =====
// testbench top for the four-square cipher engine: clock, reset, request stimulus and verdict
module four_square_digraph_cipher_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import fsq_pkg::*;

   // request codes the block does not define
   localparam logic [2:0] REQ_SPARE_6 = 3'd6;
   localparam logic [2:0] REQ_SPARE_7 = 3'd7;
   localparam int         CYCLE_LIMIT = 1000000;

   logic       clock              = 1'b0;
   logic       reset              = 1'b1;
   logic       req_valid          = 1'b0;
   logic       req_stall;
   logic [2:0] req_type           = REQ_CLEAR;
   letter_type req_letter_first   = '0;
   letter_type req_letter_second  = '0;
   logic       req_second_present = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall          = 1'b0;
   letter_type rsp_out_first;
   letter_type rsp_out_second;
   logic       rsp_status;

   int error_count;
   int pending_count;
   int cycle_count   = 0;
   int tx_idle_pct   = 0;
   int rx_stall_pct  = 0;
   int requests_sent = 0;

   four_square_digraph_cipher_top i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_type           (req_type),
      .req_letter_first   (req_letter_first),
      .req_letter_second  (req_letter_second),
      .req_second_present (req_second_present),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_first      (rsp_out_first),
      .rsp_out_second     (rsp_out_second),
      .rsp_status         (rsp_status)
   );

   four_square_digraph_cipher_checker i_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_type           (req_type),
      .req_letter_first   (req_letter_first),
      .req_letter_second  (req_letter_second),
      .req_second_present (req_second_present),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_first      (rsp_out_first),
      .rsp_out_second     (rsp_out_second),
      .rsp_status         (rsp_status),
      .error_count        (error_count),
      .pending_count      (pending_count)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // random result back-pressure
   always @(posedge clock) begin
      rsp_stall <= !reset && ($urandom_range(99) < rx_stall_pct);
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // letter code from an uppercase character
   function automatic letter_type letter_of(input byte c);
      return letter_type'(c - "A");
   endfunction

   // mostly real letters, sometimes the codes above Z
   function automatic letter_type random_letter();
      return ($urandom_range(99) < 88) ? 5'($urandom_range(25)) : 5'($urandom_range(31));
   endfunction

   // present one request after a random gap and hold it until accepted
   task automatic send_request(input logic [2:0] kind, input letter_type first_letter,
                               input letter_type second_letter, input logic second_valid);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_type           <= kind;
      req_letter_first   <= first_letter;
      req_letter_second  <= second_letter;
      req_second_present <= second_valid;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      requests_sent++;
   endtask

   // any code, any field values
   task automatic send_noise();
      send_request(3'($urandom_range(7)), 5'($urandom_range(31)), 5'($urandom_range(31)),
                   1'($urandom_range(1)));
   endtask

   // mostly clear, key letters, finalize, then cipher pairs; noise and skipped steps mixed in
   task automatic run_cipher_session();
      int key_letters;
      int pairs;
      if ($urandom_range(99) < 90) begin
         send_request(REQ_CLEAR, random_letter(), random_letter(), 1'($urandom_range(1)));
      end
      key_letters = $urandom_range(30);
      repeat (key_letters) begin
         if ($urandom_range(99) < 6) begin
            send_noise();
         end else begin
            send_request($urandom_range(1) ? REQ_KEY1 : REQ_KEY2, random_letter(),
                         5'($urandom_range(31)), 1'($urandom_range(1)));
         end
      end
      if ($urandom_range(99) < 92) begin
         send_request(REQ_FINALIZE, random_letter(), random_letter(), 1'($urandom_range(1)));
      end
      pairs = $urandom_range(40, 5);
      repeat (pairs) begin
         if ($urandom_range(99) < 6) begin
            send_noise();
         end else begin
            send_request($urandom_range(1) ? REQ_ENCRYPT : REQ_DECRYPT, random_letter(),
                         random_letter(), $urandom_range(99) < 85);
         end
      end
   endtask

   // hold off new requests until every outstanding result is back
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) begin
         @(posedge clock);
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: phase errors, spare codes, keys with repeats, J and codes above Z
      send_request(REQ_ENCRYPT, letter_of("A"), LETTER_Z, 1'b1);
      send_request(REQ_DECRYPT, LETTER_Z, letter_of("A"), 1'b1);
      send_request(REQ_SPARE_6, 5'd31, 5'd31, 1'b1);
      send_request(REQ_SPARE_7, 5'd0, 5'd0, 1'b0);
      send_request(REQ_CLEAR, 5'd0, 5'd0, 1'b0);
      send_request(REQ_KEY1, LETTER_J, 5'd0, 1'b0);
      send_request(REQ_KEY1, letter_of("U"), 5'd0, 1'b0);
      send_request(REQ_KEY1, letter_of("M"), 5'd0, 1'b0);
      send_request(REQ_KEY1, LETTER_I, 5'd0, 1'b0);
      send_request(REQ_KEY1, 5'd31, 5'd0, 1'b0);
      send_request(REQ_KEY2, LETTER_Z, 5'd0, 1'b0);
      send_request(REQ_KEY2, letter_of("E"), 5'd0, 1'b0);
      send_request(REQ_KEY2, letter_of("A"), 5'd0, 1'b0);
      send_request(REQ_KEY2, letter_of("A"), 5'd0, 1'b0);
      send_request(REQ_KEY2, 5'd26, 5'd0, 1'b0);
      send_request(REQ_FINALIZE, 5'd0, 5'd0, 1'b0);
      send_request(REQ_KEY1, letter_of("B"), 5'd0, 1'b0);
      send_request(REQ_FINALIZE, 5'd0, 5'd0, 1'b0);
      send_request(REQ_ENCRYPT, letter_of("A"), LETTER_Z, 1'b1);
      send_request(REQ_ENCRYPT, LETTER_J, 5'd31, 1'b1);
      send_request(REQ_ENCRYPT, LETTER_Z, letter_of("Q"), 1'b0);
      send_request(REQ_DECRYPT, LETTER_Z, letter_of("A"), 1'b1);
      send_request(REQ_DECRYPT, 5'd31, LETTER_J, 1'b1);
      send_request(REQ_DECRYPT, letter_of("A"), letter_of("B"), 1'b0);
      send_request(REQ_CLEAR, 5'd31, 5'd31, 1'b1);

      // random, sender busy and receiver busy
      tx_idle_pct  <= 27;
      rx_stall_pct <= 53;
      while (requests_sent < 570) begin
         run_cipher_session();
      end
      wait_for_drain();

      // random, sender sparse and receiver less busy
      tx_idle_pct  <= 53;
      rx_stall_pct <= 27;
      while (requests_sent < 1115) begin
         run_cipher_session();
      end
      wait_for_drain();

      // random, full rate on both sides
      tx_idle_pct  <= 0;
      rx_stall_pct <= 0;
      while (requests_sent < 1660) begin
         run_cipher_session();
      end

      // drain and let any stray result show up
      wait_for_drain();
      repeat (8) @(posedge clock);
      @(negedge clock);
      if (error_count == 0 && pending_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/fsq_pkg.sv
hw/rtl/four_square_digraph_cipher_top.sv
dv/four_square_digraph_cipher_checker.sv
dv/four_square_digraph_cipher_top_tb.sv
